// File: sv/hsv_to_rgb_pixel_top_defines.svh
// assertion macros shared by the hsv to rgb pixel pipeline modules
// expects aclk and aresetn in the scope of each use
`ifndef HSV_TO_RGB_PIXEL_TOP_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HSV2RGB_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("hsv2rgb: same-cycle check failed");

// next-cycle implication, checked out of reset
`define HSV2RGB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("hsv2rgb: next-cycle check failed");

`endif

// File: sv/hsv2rgb_pkg.sv
// types and codes shared by the hsv to rgb pixel pipeline
// no dependencies
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int SECT_W    = 4;
    localparam int WGT_W     = 5;

    // hue sectors of 60 degrees, codes 6..8 match no sector
    localparam logic [SECT_W-1:0] SECT_RED_YEL = 4'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN = 4'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN = 4'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU = 4'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG = 4'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED = 4'd5;
    localparam logic [SECT_W-1:0] SECT_LAST    = 4'd8;

    localparam logic [WGT_W-1:0] WGT_MAX = 5'd30;

    typedef struct packed {
        logic [Q_W-1:0]    s_q;
        logic [Q_W-1:0]    v_q;
        logic [SECT_W-1:0] sector;
        logic [WGT_W-1:0]  wgt;
    } front_t;

    typedef struct packed {
        logic [Q_W-1:0]    c_q;
        logic [Q_W-1:0]    m_q;
        logic [Q_W-1:0]    x_q;
        logic [SECT_W-1:0] sector;
    } mix_t;

endpackage

// File: sv/hsv2rgb_front.sv
// stage 1: saturation and value to unsigned Q1.16, hue sector and weight
// depends on hsv2rgb_pkg and hsv_to_rgb_pixel_top_defines.svh
`include "hsv_to_rgb_pixel_top_defines.svh"

module hsv2rgb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            hue,
    input  logic [7:0]            sat,
    input  logic [7:0]            val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsv2rgb_pkg::front_t   out_data
);

    logic                               valid_reg, valid_next;
    hsv2rgb_pkg::front_t                data_reg, data_next;
    logic [hsv2rgb_pkg::SECT_W-1:0]     sector;
    logic [7:0]                         base;
    logic [7:0]                         rem30;

    // code * 65536 / 255 == code * 257 + (code == 255)
    function automatic logic [hsv2rgb_pkg::Q_W-1:0] to_unit(input logic [7:0] code);
        return {1'b0, code, code} + hsv2rgb_pkg::Q_W'(code == 8'hFF);
    endfunction

    always_comb begin
        sector = '0;
        for (int k = 1; k <= 8; k++) begin
            if (hue >= 8'(k * 30)) begin
                sector = hsv2rgb_pkg::SECT_W'(k);
            end
        end
        base  = 8'(32'(sector) * 32'd30);
        rem30 = hue - base;
    end

    always_comb begin
        data_next.s_q    = to_unit(sat);
        data_next.v_q    = to_unit(val);
        data_next.sector = sector;
        // odd sectors fall from 30 to 1, even ones rise from 0 to 29
        data_next.wgt    = sector[0] ? (hsv2rgb_pkg::WGT_MAX - rem30[4:0]) : rem30[4:0];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `HSV2RGB_ASSERT_NOW(a_front_range, valid_reg,
        (data_reg.wgt <= hsv2rgb_pkg::WGT_MAX) && (data_reg.sector <= hsv2rgb_pkg::SECT_LAST))

endmodule

// File: sv/hsv2rgb_chroma.sv
// stages 2 to 4: chroma, offset and mid value through three multiplies
// depends on hsv2rgb_pkg and hsv_to_rgb_pixel_top_defines.svh
`include "hsv_to_rgb_pixel_top_defines.svh"

module hsv2rgb_chroma (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsv2rgb_pkg::front_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsv2rgb_pkg::mix_t     out_data
);

    localparam int Q_W    = hsv2rgb_pkg::Q_W;
    localparam int P_W    = Q_W + hsv2rgb_pkg::WGT_W;
    // floor(p / 30) == (p * ceil(2^26 / 30)) >> 26 for every p below 2^21
    localparam int RCP_SH = 26;
    localparam int RCP_W  = 22;
    localparam logic [RCP_W-1:0] RCP_30 = 22'd2236963;
    localparam int PROD_W = P_W + RCP_W;

    logic                               v2_reg, v3_reg, v4_reg;
    logic                               r2, r3, r4;
    logic [Q_W-1:0]                     c2_reg, v2q_reg;
    logic [hsv2rgb_pkg::SECT_W-1:0]     sect2_reg, sect3_reg;
    logic [hsv2rgb_pkg::WGT_W-1:0]      wgt2_reg;
    logic [Q_W-1:0]                     c3_reg, m3_reg;
    logic [P_W-1:0]                     p3_reg;
    hsv2rgb_pkg::mix_t                  s4_reg;
    logic [2*Q_W-1:0]                   vs_prod;
    logic [PROD_W-1:0]                  x_prod;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign in_ready = r2;

    assign vs_prod = in_data.v_q * in_data.s_q;
    assign x_prod  = p3_reg * RCP_30;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r2) begin
                v2_reg <= in_valid;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r2 && in_valid) begin
            c2_reg    <= vs_prod[hsv2rgb_pkg::FRAC_BITS +: Q_W];
            v2q_reg   <= in_data.v_q;
            sect2_reg <= in_data.sector;
            wgt2_reg  <= in_data.wgt;
        end
        if (r3 && v2_reg) begin
            c3_reg    <= c2_reg;
            m3_reg    <= v2q_reg - c2_reg;
            p3_reg    <= c2_reg * wgt2_reg;
            sect3_reg <= sect2_reg;
        end
        if (r4 && v3_reg) begin
            s4_reg.c_q    <= c3_reg;
            s4_reg.m_q    <= m3_reg;
            s4_reg.x_q    <= x_prod[RCP_SH +: Q_W];
            s4_reg.sector <= sect3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

    `HSV2RGB_ASSERT_NOW(a_chroma_le_value, v2_reg, c2_reg <= v2q_reg)
    `HSV2RGB_ASSERT_NOW(a_mid_le_chroma, v4_reg, s4_reg.x_q <= s4_reg.c_q)
    `HSV2RGB_ASSERT_NEXT(a_stage3_kept, v3_reg && !r4, v3_reg)

endmodule

// File: sv/hsv2rgb_mix.sv
// stage 5: channel order by sector, offset add and scaling to bytes
// depends on hsv2rgb_pkg and hsv_to_rgb_pixel_top_defines.svh
`include "hsv_to_rgb_pixel_top_defines.svh"

module hsv2rgb_mix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsv2rgb_pkg::mix_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);

    localparam int Q_W = hsv2rgb_pkg::Q_W;

    logic             valid_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;
    logic [Q_W-1:0]   rp, gp, bp;

    // (q * 255) >> 16, with q never above 1.0
    function automatic logic [7:0] to_byte(input logic [Q_W-1:0] q);
        logic [Q_W+7:0] t;
        t = {q, 8'b0} - {8'b0, q};
        return t[hsv2rgb_pkg::FRAC_BITS +: 8];
    endfunction

    always_comb begin
        rp = '0;
        gp = '0;
        bp = '0;
        case (in_data.sector)
            hsv2rgb_pkg::SECT_RED_YEL: begin
                rp = in_data.c_q;
                gp = in_data.x_q;
            end
            hsv2rgb_pkg::SECT_YEL_GRN: begin
                rp = in_data.x_q;
                gp = in_data.c_q;
            end
            hsv2rgb_pkg::SECT_GRN_CYN: begin
                gp = in_data.c_q;
                bp = in_data.x_q;
            end
            hsv2rgb_pkg::SECT_CYN_BLU: begin
                gp = in_data.x_q;
                bp = in_data.c_q;
            end
            hsv2rgb_pkg::SECT_BLU_MAG: begin
                rp = in_data.x_q;
                bp = in_data.c_q;
            end
            hsv2rgb_pkg::SECT_MAG_RED: begin
                rp = in_data.c_q;
                bp = in_data.x_q;
            end
            default: begin
                // hue out of range, gray at the offset
                rp = '0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg   <= to_byte(rp + in_data.m_q);
            green_reg <= to_byte(gp + in_data.m_q);
            blue_reg  <= to_byte(bp + in_data.m_q);
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    `HSV2RGB_ASSERT_NOW(a_sum_le_one, in_valid,
        ((Q_W+1)'(in_data.c_q) + (Q_W+1)'(in_data.m_q)) <= (Q_W+1)'(65536))

endmodule

// File: sv/hsv_to_rgb_pixel_top.sv
// top level of the hsv to rgb pixel converter, five register stages
// depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_chroma and hsv2rgb_mix
//
// usage:
//   s_ channel takes one hsv pixel per beat, m_ channel gives one rgb pixel
//   per beat, in the same order, one result for every input beat.
//   hue counts two degrees per step; codes 180 and up give gray at the
//   offset level, value minus chroma.
// throughput: one pixel per clock while m_tready is high; a beat passes
//   the five stages in order before m_tvalid: front conversion, chroma
//   multiply, mid-value weight multiply, reciprocal multiply for the
//   division by 30, and the channel mix with byte scaling.
// reset: aresetn low at a rising edge empties every stage; results in
//   flight are dropped and m_tvalid goes low.
// stall: with m_tready low the output beat holds; each stage has its own
//   ready, so bubbles inside the pipe still fill and s_tready drops only
//   once every stage holds a pixel.

module hsv_to_rgb_pixel_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue [7:0], sat [15:8], val [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red [7:0], green [15:8], blue [23:16]
);

    logic                   f_valid, f_ready;
    hsv2rgb_pkg::front_t    f_data;
    logic                   c_valid, c_ready;
    hsv2rgb_pkg::mix_t      c_data;
    logic [7:0]             red, green, blue;

    hsv2rgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue       (s_tdata[7:0]),
        .sat       (s_tdata[15:8]),
        .val       (s_tdata[23:16]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    hsv2rgb_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    hsv2rgb_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule
